>>> sv/ppfm_pkg.sv
// ============================================================================
// ppfm_pkg - shared types and constants of the pulse period/frequency meter
// Field widths, stream packing, register indexes, state encodings and the
// display limit function used by the front end, back end and checker.
// ============================================================================
`default_nettype none

package ppfm_pkg;

    // parameter defaults
    localparam int COUNT_BITS_DEF  = 16;
    localparam int DIGIT_COUNT_DEF = 5;

    // fixed field widths
    localparam int RATE_W       = 27;
    localparam int MULT_W       = 3;
    localparam int VALUE_W      = 17;
    localparam int DIGIT_W      = 4;
    localparam int FIELD_DIGITS = 5;
    localparam int BCD_W        = FIELD_DIGITS * DIGIT_W;

    // stream and config port widths
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = 2;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = RATE_W;

    // tuser bit positions
    localparam int TUSER_QTY = 0;
    localparam int TUSER_OVF = 1;

    // quantity codes
    localparam logic QTY_PERIOD = 1'b0;
    localparam logic QTY_FREQ   = 1'b1;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_TICK_RATE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MULT      = 1'd1;

    // register reset values
    localparam logic [RATE_W-1:0] TICK_RATE_RESET = 27'd1000000;
    localparam logic [MULT_W-1:0] MULT_RESET      = 3'd2;

    // back end sequencing
    localparam int DIV_STEPS  = RATE_W;
    localparam int CONV_STEPS = VALUE_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // measurement queue
    localparam int QUEUE_DEPTH = 2;

    // front end phase
    typedef enum logic [1:0] {
        PH_WAIT_LOW  = 2'd0,
        PH_WAIT_RISE = 2'd1,
        PH_COUNT     = 2'd2
    } phase_t;

    // back end sequencer state
    typedef enum logic [2:0] {
        BK_IDLE = 3'd0,
        BK_MUL  = 3'd1,
        BK_DIV  = 3'd2,
        BK_CONV = 3'd3,
        BK_PUT  = 3'd4
    } back_state_t;

    // queue status toward producer and consumer
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // largest shown value: 10^min(digits, five) - 1
    function automatic int display_limit(input int digits);
        int lim;
        lim = 1;
        for (int i = 0; i < FIELD_DIGITS; i++) begin
            if (i < digits) begin
                lim = lim * 10;
            end
        end
        return lim - 1;
    endfunction

endpackage

`default_nettype wire

>>> sv/ppfm_front.sv
// ============================================================================
// ppfm_front - edge detection and high-time counter
// Takes one tick per clock while the queue has room, tracks the pulse phase,
// counts high ticks with saturation and queues each finished measurement.
// ============================================================================
`default_nettype none

module ppfm_front #(
    parameter int COUNT_BITS = ppfm_pkg::COUNT_BITS_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [ppfm_pkg::S_TDATA_W-1:0]  s_tdata,   // [0] pulse_level
    input  ppfm_pkg::q_status_t             q_status,
    output logic                            q_push,
    output logic [COUNT_BITS:0]             q_wdata    // {saturated, count}
);

    ppfm_pkg::phase_t       phase_reg, phase_next;
    logic [COUNT_BITS-1:0]  count_reg;
    logic                   sat_reg;
    logic                   accept;
    logic                   level;
    logic                   cnt_start;
    logic                   cnt_inc;
    logic                   cnt_at_max;

    assign s_tready   = !q_status.full;
    assign accept     = s_tvalid && s_tready;
    assign level      = s_tdata[0];
    assign cnt_at_max = (count_reg == {COUNT_BITS{1'b1}});
    assign q_wdata    = {sat_reg, count_reg};

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            unique case (phase_reg)
                ppfm_pkg::PH_WAIT_RISE: begin
                    if (level) phase_next = ppfm_pkg::PH_COUNT;
                end
                ppfm_pkg::PH_COUNT: begin
                    if (!level) phase_next = ppfm_pkg::PH_WAIT_RISE;
                end
                default: begin
                    // waiting for low, also the unused code
                    phase_next = level ? ppfm_pkg::PH_WAIT_LOW : ppfm_pkg::PH_WAIT_RISE;
                end
            endcase
        end
    end

    // phase outputs
    always_comb begin
        cnt_start = 1'b0;
        cnt_inc   = 1'b0;
        q_push    = 1'b0;
        if (accept) begin
            unique case (phase_reg)
                ppfm_pkg::PH_WAIT_RISE: begin
                    cnt_start = level;
                end
                ppfm_pkg::PH_COUNT: begin
                    cnt_inc = level;
                    q_push  = !level;
                end
                default: begin
                end
            endcase
        end
    end

    // phase, counter and saturation flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ppfm_pkg::PH_WAIT_LOW;
            count_reg <= '0;
            sat_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            if (cnt_start) begin
                count_reg <= COUNT_BITS'(1);
                sat_reg   <= 1'b0;
            end else if (cnt_inc) begin
                if (cnt_at_max) sat_reg <= 1'b1;
                else count_reg <= count_reg + COUNT_BITS'(1);
            end else if (q_push) begin
                count_reg <= '0;
                sat_reg   <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/ppfm_queue.sv
// ============================================================================
// ppfm_queue - short measurement queue
// Small FIFO between front and back end so that each side stalls on its own.
// ============================================================================
`default_nettype none

module ppfm_queue #(
    parameter int DATA_W = ppfm_pkg::COUNT_BITS_DEF + 1,
    parameter int DEPTH  = ppfm_pkg::QUEUE_DEPTH
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push,
    input  wire  [DATA_W-1:0]   wdata,
    input  wire                 pop,
    output logic [DATA_W-1:0]   rdata,
    output ppfm_pkg::q_status_t status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (fill_reg == CNT_W'(DEPTH));
    assign status.empty = (fill_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= wdata;
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                               : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                               : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) fill_reg <= fill_reg + CNT_W'(1);
            else if (do_pop && !do_push) fill_reg <= fill_reg - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

>>> sv/ppfm_back.sv
// ============================================================================
// ppfm_back - period, frequency and decimal conversion
// Sequencer that multiplies the count into a period, divides the tick rate
// by it one quotient bit a cycle, converts both values to decimal one bit a
// cycle and hands them to the output register.
// ============================================================================
`default_nettype none

module ppfm_back #(
    parameter int COUNT_BITS  = ppfm_pkg::COUNT_BITS_DEF,
    parameter int DIGIT_COUNT = ppfm_pkg::DIGIT_COUNT_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire  [ppfm_pkg::RATE_W-1:0]     tick_rate,
    input  wire  [ppfm_pkg::MULT_W-1:0]     mult,
    input  ppfm_pkg::q_status_t             q_status,
    input  wire  [COUNT_BITS:0]             q_rdata,   // {saturated, count}
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // [16:0] shown_value, [20:17] digit_ten_thousands, [24:21] digit_thousands,
    // [28:25] digit_hundreds, [32:29] digit_tens, [36:33] digit_units
    output logic [ppfm_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [ppfm_pkg::M_TUSER_W-1:0]  m_tuser,   // [0] quantity, [1] overflow
    output logic                            m_tlast    // last_of_run
);

    localparam int RATE_W  = ppfm_pkg::RATE_W;
    localparam int VALUE_W = ppfm_pkg::VALUE_W;
    localparam int BCD_W   = ppfm_pkg::BCD_W;
    localparam int DIGIT_W = ppfm_pkg::DIGIT_W;
    localparam int STEP_W  = ppfm_pkg::STEP_W;
    localparam int PROD_W  = COUNT_BITS + ppfm_pkg::MULT_W;
    localparam int DIVD_W  = RATE_W + 1;
    localparam int CMP_W   = (PROD_W > DIVD_W) ? PROD_W : DIVD_W;
    localparam int PAD_W   = ppfm_pkg::M_TDATA_W - VALUE_W - BCD_W;
    localparam logic [VALUE_W-1:0] LIMIT = VALUE_W'(ppfm_pkg::display_limit(DIGIT_COUNT));

    ppfm_pkg::back_state_t  state_reg, state_next;
    logic [COUNT_BITS-1:0]  count_reg;
    logic                   csat_reg;
    logic [PROD_W-1:0]      period_reg;
    logic [RATE_W-1:0]      rem_reg;
    logic [RATE_W-1:0]      dq_reg;       // dividend in, quotient out
    logic [STEP_W-1:0]      step_reg;
    logic [VALUE_W-1:0]     val_reg;
    logic [VALUE_W-1:0]     bin_reg;
    logic [BCD_W-1:0]       bcd_reg;
    logic                   ovf_reg;
    logic                   sel_reg;
    logic                   m_tvalid_reg;

    logic [PROD_W-1:0]      product;
    logic [DIVD_W-1:0]      rem_sh;
    logic [CMP_W-1:0]       rem_ext;
    logic [CMP_W-1:0]       per_ext;
    logic [CMP_W-1:0]       diff;
    logic                   ge;
    logic                   period_sat;
    logic [VALUE_W-1:0]     period_val;
    logic                   freq_sat;
    logic [VALUE_W-1:0]     freq_val;
    logic [BCD_W-1:0]       bcd_adj;
    logic [BCD_W-1:0]       bcd_shift;
    logic [VALUE_W-1:0]     bin_shift;
    logic                   out_free;
    logic                   load_out;
    logic                   div_last;
    logic                   conv_last;

    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // period product
    assign product = PROD_W'(count_reg) * PROD_W'(mult);

    // restoring divide step
    assign rem_sh  = {rem_reg, dq_reg[RATE_W-1]};
    assign rem_ext = CMP_W'(rem_sh);
    assign per_ext = CMP_W'(period_reg);
    assign diff    = rem_ext - per_ext;
    assign ge      = (rem_ext >= per_ext);

    // display saturation
    assign period_sat = (per_ext > CMP_W'(LIMIT));
    assign period_val = period_sat ? LIMIT : VALUE_W'(period_reg);
    assign freq_sat   = (period_reg == '0) || (CMP_W'(dq_reg) > CMP_W'(LIMIT));
    assign freq_val   = freq_sat ? LIMIT : VALUE_W'(dq_reg);

    // shift-and-add-3 conversion step
    always_comb begin
        for (int i = 0; i < ppfm_pkg::FIELD_DIGITS; i++) begin
            bcd_adj[i*DIGIT_W +: DIGIT_W] =
                (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) ?
                bcd_reg[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3) :
                bcd_reg[i*DIGIT_W +: DIGIT_W];
        end
    end
    assign {bcd_shift, bin_shift} = {bcd_adj[BCD_W-2:0], bin_reg, 1'b0};

    assign div_last  = (step_reg == STEP_W'(ppfm_pkg::DIV_STEPS - 1));
    assign conv_last = (step_reg == STEP_W'(ppfm_pkg::CONV_STEPS - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ppfm_pkg::BK_IDLE: if (!q_status.empty) state_next = ppfm_pkg::BK_MUL;
            ppfm_pkg::BK_MUL:  state_next = ppfm_pkg::BK_DIV;
            ppfm_pkg::BK_DIV:  if (div_last) state_next = ppfm_pkg::BK_CONV;
            ppfm_pkg::BK_CONV: if (conv_last) state_next = ppfm_pkg::BK_PUT;
            ppfm_pkg::BK_PUT: begin
                if (out_free) begin
                    state_next = (sel_reg == ppfm_pkg::QTY_PERIOD) ? ppfm_pkg::BK_CONV
                                                                   : ppfm_pkg::BK_IDLE;
                end
            end
            default: state_next = ppfm_pkg::BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        q_pop    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ppfm_pkg::BK_IDLE: q_pop    = !q_status.empty;
            ppfm_pkg::BK_PUT:  load_out = out_free;
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ppfm_pkg::BK_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ppfm_pkg::BK_MUL) step_reg <= '0;
            else if (state_reg == ppfm_pkg::BK_DIV) step_reg <= div_last ? '0 : step_reg + STEP_W'(1);
            else if (state_reg == ppfm_pkg::BK_CONV) step_reg <= conv_last ? '0 : step_reg + STEP_W'(1);
            if (load_out) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ppfm_pkg::BK_IDLE: begin
                if (q_pop) {csat_reg, count_reg} <= q_rdata;
            end
            ppfm_pkg::BK_MUL: begin
                period_reg <= product;
                rem_reg    <= '0;
                dq_reg     <= tick_rate;
            end
            ppfm_pkg::BK_DIV: begin
                rem_reg <= ge ? diff[RATE_W-1:0] : rem_sh[RATE_W-1:0];
                dq_reg  <= {dq_reg[RATE_W-2:0], ge};
                if (div_last) begin
                    val_reg <= period_val;
                    bin_reg <= period_val;
                    bcd_reg <= '0;
                    ovf_reg <= period_sat || csat_reg;
                    sel_reg <= ppfm_pkg::QTY_PERIOD;
                end
            end
            ppfm_pkg::BK_CONV: begin
                bcd_reg <= bcd_shift;
                bin_reg <= bin_shift;
            end
            ppfm_pkg::BK_PUT: begin
                if (out_free && sel_reg == ppfm_pkg::QTY_PERIOD) begin
                    val_reg <= freq_val;
                    bin_reg <= freq_val;
                    bcd_reg <= '0;
                    ovf_reg <= freq_sat || csat_reg;
                    sel_reg <= ppfm_pkg::QTY_FREQ;
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata <= {{PAD_W{1'b0}},
                        bcd_reg[3:0], bcd_reg[7:4], bcd_reg[11:8],
                        bcd_reg[15:12], bcd_reg[19:16], val_reg};
            m_tuser[ppfm_pkg::TUSER_QTY] <= sel_reg;
            m_tuser[ppfm_pkg::TUSER_OVF] <= ovf_reg;
            m_tlast <= (sel_reg == ppfm_pkg::QTY_FREQ);
        end
    end

endmodule

`default_nettype wire

>>> sv/pulse_period_frequency_meter_unit.sv
// ============================================================================
// pulse_period_frequency_meter_unit - gated timer pulse period/frequency meter
// Each input item is one timer tick carrying the sampled pulse level; the
// front end takes one tick every clock while its two-entry measurement queue
// has room. It waits for a low level, then a rising edge, counts high ticks
// (saturating) and on the falling edge queues the count. The back end works
// one measurement at a time: a multiply, a bit-serial divide of the tick
// rate by the period, then decimal conversion and a hand-off for each of
// the two results. The period result comes first, the frequency result
// second with tlast set. Ticks keep flowing as long as the back end keeps
// up with the measurements on average; otherwise s_tready drops once the
// queue is full. Configuration writes must be made only while no measurement
// is in flight.
// ============================================================================
`default_nettype none

module pulse_period_frequency_meter_unit #(
    parameter int COUNT_BITS  = ppfm_pkg::COUNT_BITS_DEF,
    parameter int DIGIT_COUNT = ppfm_pkg::DIGIT_COUNT_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [ppfm_pkg::S_TDATA_W-1:0]   s_tdata,   // [0] pulse_level
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // [16:0] shown_value, [20:17] digit_ten_thousands, [24:21] digit_thousands,
    // [28:25] digit_hundreds, [32:29] digit_tens, [36:33] digit_units
    output logic [ppfm_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [ppfm_pkg::M_TUSER_W-1:0]   m_tuser,   // [0] quantity, [1] overflow
    output logic                             m_tlast,   // last_of_run
    input  wire                              cfg_we,
    input  wire  [ppfm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire  [ppfm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic [ppfm_pkg::RATE_W-1:0] tick_rate_reg;
    logic [ppfm_pkg::MULT_W-1:0] mult_reg;
    ppfm_pkg::q_status_t         q_status;
    logic                        q_push;
    logic                        q_pop;
    logic [COUNT_BITS:0]         q_wdata;
    logic [COUNT_BITS:0]         q_rdata;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_rate_reg <= ppfm_pkg::TICK_RATE_RESET;
            mult_reg      <= ppfm_pkg::MULT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                ppfm_pkg::CFG_TICK_RATE: tick_rate_reg <= cfg_wdata[ppfm_pkg::RATE_W-1:0];
                ppfm_pkg::CFG_MULT:      mult_reg      <= cfg_wdata[ppfm_pkg::MULT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ppfm_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_status (q_status),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    ppfm_queue #(
        .DATA_W (COUNT_BITS + 1),
        .DEPTH  (ppfm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .status  (q_status)
    );

    ppfm_back #(
        .COUNT_BITS  (COUNT_BITS),
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick_rate (tick_rate_reg),
        .mult      (mult_reg),
        .q_status  (q_status),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

>>> sv/ppfm_checker.sv
// ============================================================================
// ppfm_checker - port-level checks of the pulse period/frequency meter
// Watches the result stream: reset behavior, stall hold, run marking and
// consistency of the decimal digits with the shown value.
// ============================================================================
`default_nettype none

module ppfm_checker (
    input wire                             aclk,
    input wire                             aresetn,
    input wire                             m_tvalid,
    input wire                             m_tready,
    input wire [ppfm_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire [ppfm_pkg::M_TUSER_W-1:0]   m_tuser,
    input wire                             m_tlast
);

    logic [31:0] digit_sum;
    logic        digits_ok;

    // digits recombined
    assign digit_sum = 32'(m_tdata[20:17]) * 32'd10000 + 32'(m_tdata[24:21]) * 32'd1000
                     + 32'(m_tdata[28:25]) * 32'd100 + 32'(m_tdata[32:29]) * 32'd10
                     + 32'(m_tdata[36:33]);
    assign digits_ok = (m_tdata[20:17] <= 4'd9) && (m_tdata[24:21] <= 4'd9)
                    && (m_tdata[28:25] <= 4'd9) && (m_tdata[32:29] <= 4'd9)
                    && (m_tdata[36:33] <= 4'd9);

    // nothing offered right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // frequency result and only it ends the run
    a_last_marks_freq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser[ppfm_pkg::TUSER_QTY] == ppfm_pkg::QTY_FREQ)))
        else $error("tlast does not match quantity");

    // digits are decimal and spell the shown value
    a_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> digits_ok && (digit_sum == 32'(m_tdata[16:0])))
        else $error("digits disagree with shown value");

endmodule

bind pulse_period_frequency_meter_unit ppfm_checker u_ppfm_checker (.*);

`default_nettype wire
